@@ design/tsch_pkg.sv @@
// Shared types and codes of the timeout scheduler.
`default_nettype none
package tsch_pkg;

	localparam int unsigned POOL_SLOTS_DEF  = 16;
	localparam int unsigned ACTION_BITS_DEF = 8;

	localparam logic [1:0] KIND_SCHED  = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;
	localparam logic [1:0] KIND_RSVD   = 2'd3;

	localparam logic RES_REPLY = 1'b0;
	localparam logic RES_FIRED = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] now;
		logic [31:0] delay;
		logic [7:0]  action_tag;
		logic [3:0]  handle_slot;
		logic [31:0] handle_version;
	} req_t;

	typedef struct packed {
		logic        result_kind;
		logic        ok;
		logic [3:0]  out_slot;
		logic [31:0] out_version;
		logic [7:0]  fired_action;
		logic [31:0] fire_time;
		logic        last;
	} rsp_t;

endpackage
`default_nettype wire

@@ design/tsch_slot_ram.sv @@
// Slot memory: one write port, one read port, registered read data.
`default_nettype none
module tsch_slot_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 104,
	parameter int unsigned AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ design/timeout_scheduler.sv @@
// Timeout scheduler top level: slot flags, sequencer and output register.
//
//  channel | signals                        | role
//  req     | req_valid, req_ready, req      | schedule / cancel / tick transactions
//  rsp     | rsp_valid, rsp_ready, rsp      | schedule replies and fired timeouts
//
// Schedule: accept, then a write state that waits for the output register to be free;
// cancel: slot read at accept, then compare. Tick: accept, an activation pass over all
// slots, then per expired timer a scan over all slots and a decide step, plus one final
// scan, decide and flush step.
// Reset clears flags, counters and control; slot memory contents need no reset.
// A stalled rsp holds the output register and the one held fired result;
// req is taken only when the sequencer is idle.
`default_nettype none
module timeout_scheduler #(
	parameter int unsigned POOL_SLOTS  = tsch_pkg::POOL_SLOTS_DEF,
	parameter int unsigned ACTION_BITS = tsch_pkg::ACTION_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire tsch_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output tsch_pkg::rsp_t      rsp
);
	import tsch_pkg::*;

	localparam int unsigned SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int unsigned CW = $clog2(POOL_SLOTS + 1);
	localparam int unsigned EW = 96 + ACTION_BITS;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCHED  = 3'd1;
	localparam logic [2:0] ST_CANCEL = 3'd2;
	localparam logic [2:0] ST_ACT    = 3'd3;
	localparam logic [2:0] ST_SCAN   = 3'd4;
	localparam logic [2:0] ST_DECIDE = 3'd5;
	localparam logic [2:0] ST_FLUSH  = 3'd6;

	function automatic logic [3:0] slot4(input logic [SW-1:0] s);
		logic [31:0] w;
		w = 32'(s);
		return w[3:0];
	endfunction

	function automatic logic [7:0] act8(input logic [ACTION_BITS-1:0] a);
		logic [31:0] w;
		w = 32'(a);
		return w[7:0];
	endfunction

	logic [2:0]             st_q;
	req_t                   item_q;
	logic [POOL_SLOTS-1:0]  inuse_q, pend_q, canc_q;
	logic [31:0]            nver_q, base_q;
	logic [CW-1:0]          pcnt_q, idx_q;
	logic                   v_s1;
	logic [SW-1:0]          slot_s1;
	logic                   best_v_q;
	logic [SW-1:0]          best_slot_q;
	logic [31:0]            best_due_q, best_rank_q, best_ver_q;
	logic [ACTION_BITS-1:0] best_act_q;
	logic                   held_v_q;
	rsp_t                   held_q;
	logic                   out_v_q;
	rsp_t                   out_q;

	logic                   we;
	logic [SW-1:0]          waddr, raddr;
	logic [EW-1:0]          wdata, rdata;

	logic [31:0]            r_due, r_ver, r_rank;
	logic [ACTION_BITS-1:0] r_act;
	logic [POOL_SLOTS-1:0]  free_mask, reclaim, pick_mask, inuse_sched;
	logic                   sel_ok;
	logic [SW-1:0]          sel_slot;
	logic                   can_push, push, fire, better, cand_act;
	rsp_t                   push_data, fired;
	logic [31:0]            tag32, hs32;
	logic [SW-1:0]          req_hs, item_hs;
	logic                   hs_ok, idx_end;

	assign r_due  = rdata[EW-1 -: 32];
	assign r_ver  = rdata[EW-33 -: 32];
	assign r_rank = rdata[EW-65 -: 32];
	assign r_act  = rdata[ACTION_BITS-1:0];

	assign tag32    = 32'(item_q.action_tag);
	assign hs32     = 32'(item_q.handle_slot);
	assign item_hs  = hs32[SW-1:0];
	assign hs_ok    = hs32 < POOL_SLOTS;
	assign can_push = !out_v_q || rsp_ready;
	assign idx_end  = (32'(idx_q) >= POOL_SLOTS);

	always_comb begin
		logic [31:0] rq;
		rq     = 32'(req.handle_slot);
		req_hs = rq[SW-1:0];
	end

	// lowest free slot, else lowest cancelled active slot
	always_comb begin
		free_mask = ~inuse_q;
		reclaim   = inuse_q & ~pend_q & canc_q;
		pick_mask = (|free_mask) ? free_mask : reclaim;
		sel_ok    = |pick_mask;
		sel_slot  = '0;
		for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
			if (pick_mask[i]) begin
				sel_slot = SW'(i);
			end
		end
		inuse_sched = (|free_mask) ? inuse_q : (inuse_q & ~reclaim);
		inuse_sched[sel_slot] = 1'b1;
	end

	assign cand_act = inuse_q[slot_s1] && !pend_q[slot_s1];
	assign better   = !best_v_q || (r_due < best_due_q) ||
		((r_due == best_due_q) && (r_rank < best_rank_q));
	assign fire     = best_v_q && !(item_q.now < best_due_q);

	always_comb begin
		fired = '{result_kind: RES_FIRED, ok: 1'b0, out_slot: slot4(best_slot_q),
			out_version: best_ver_q, fired_action: act8(best_act_q),
			fire_time: item_q.now, last: 1'b0};
	end

	always_comb begin
		push      = 1'b0;
		push_data = held_q;
		unique case (st_q)
			ST_SCHED: begin
				push      = can_push;
				push_data = '{result_kind: RES_REPLY, ok: sel_ok, out_slot: slot4(sel_slot),
					out_version: sel_ok ? nver_q : 32'd0, fired_action: 8'd0,
					fire_time: 32'd0, last: 1'b1};
			end
			ST_DECIDE: begin
				push = fire && !canc_q[best_slot_q] && held_v_q && can_push;
			end
			ST_FLUSH: begin
				push           = held_v_q && can_push;
				push_data.last = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = slot_s1;
		wdata = {r_due, r_ver, base_q + 32'(pcnt_q) - 32'd1 - r_rank, r_act};
		raddr = (st_q == ST_IDLE) ? req_hs : idx_q[SW-1:0];
		if (st_q == ST_SCHED) begin
			we    = can_push && sel_ok;
			waddr = sel_slot;
			wdata = {item_q.now + item_q.delay, nver_q, 32'(pcnt_q),
				tag32[ACTION_BITS-1:0]};
		end else if (st_q == ST_ACT) begin
			we = v_s1 && pend_q[slot_s1];
		end
	end

	tsch_slot_ram #(
		.DEPTH(POOL_SLOTS),
		.WIDTH(EW),
		.AW   (SW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			inuse_q  <= '0;
			pend_q   <= '0;
			canc_q   <= '0;
			nver_q   <= '0;
			base_q   <= '0;
			pcnt_q   <= '0;
			idx_q    <= '0;
			v_s1     <= 1'b0;
			best_v_q <= 1'b0;
			held_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (push) begin
				out_v_q <= 1'b1;
			end else if (rsp_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (req_valid) begin
						priority case (req.kind)
							KIND_SCHED:  st_q <= ST_SCHED;
							KIND_CANCEL: st_q <= ST_CANCEL;
							KIND_TICK: begin
								st_q  <= ST_ACT;
								idx_q <= '0;
								v_s1  <= 1'b0;
							end
							default: st_q <= ST_IDLE;
						endcase
					end
				end
				ST_SCHED: begin
					if (can_push) begin
						if (sel_ok) begin
							inuse_q          <= inuse_sched;
							pend_q[sel_slot] <= 1'b1;
							canc_q[sel_slot] <= 1'b0;
							nver_q           <= nver_q + 32'd1;
							pcnt_q           <= pcnt_q + CW'(1);
						end
						st_q <= ST_IDLE;
					end
				end
				ST_CANCEL: begin
					if (hs_ok && inuse_q[item_hs] && (r_ver == item_q.handle_version)) begin
						canc_q[item_hs] <= 1'b1;
					end
					st_q <= ST_IDLE;
				end
				ST_ACT: begin
					v_s1    <= !idx_end;
					slot_s1 <= idx_q[SW-1:0];
					if (!idx_end) begin
						idx_q <= idx_q + CW'(1);
					end
					if (v_s1) begin
						pend_q[slot_s1] <= 1'b0;
					end
					if (idx_end && !v_s1) begin
						base_q   <= base_q + 32'(pcnt_q);
						pcnt_q   <= '0;
						idx_q    <= '0;
						best_v_q <= 1'b0;
						st_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					v_s1    <= !idx_end;
					slot_s1 <= idx_q[SW-1:0];
					if (!idx_end) begin
						idx_q <= idx_q + CW'(1);
					end
					if (v_s1 && cand_act && better) begin
						best_v_q    <= 1'b1;
						best_slot_q <= slot_s1;
						best_due_q  <= r_due;
						best_rank_q <= r_rank;
						best_ver_q  <= r_ver;
						best_act_q  <= r_act;
					end
					if (idx_end && !v_s1) begin
						st_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!fire) begin
						st_q <= ST_FLUSH;
					end else if (canc_q[best_slot_q] || !held_v_q || can_push) begin
						// retire the winner and scan again
						inuse_q[best_slot_q] <= 1'b0;
						if (!canc_q[best_slot_q]) begin
							held_v_q <= 1'b1;
							held_q   <= fired;
						end
						idx_q    <= '0;
						v_s1     <= 1'b0;
						best_v_q <= 1'b0;
						st_q     <= ST_SCAN;
					end
				end
				ST_FLUSH: begin
					if (!held_v_q) begin
						st_q <= ST_IDLE;
					end else if (can_push) begin
						held_v_q <= 1'b0;
						st_q     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && req_valid) begin
			item_q <= req;
		end
		if (push) begin
			out_q <= push_data;
		end
	end

	assign req_ready = (st_q == ST_IDLE);
	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	a_pend_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & ~inuse_q) == '0)
		else $error("pending slot not in use");
	// pending flags drain one by one during activation, the count at its end
	a_pcnt: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_ACT) |-> (32'(pcnt_q) == $countones(pend_q)))
		else $error("pending count out of step with flags");
	a_idle_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !held_v_q)
		else $error("held fired result left behind at idle");
	a_act_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ACT) |-> !held_v_q)
		else $error("held result during activation");

endmodule
`default_nettype wire

@@ tb/timeout_scheduler_tb.sv @@
// Self-checking testbench for the timeout scheduler: schedule, cancel and tick traffic.
`timescale 1ns / 100ps
`default_nettype none
module timeout_scheduler_tb;
	import tsch_pkg::*;

	localparam int NSLOT = 16;
	localparam int RAND_ITEMS = 307;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	timeout_scheduler i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow timer pool
	logic [31:0] t_due [NSLOT];
	logic [7:0]  t_act [NSLOT];
	logic [31:0] t_ver [NSLOT];
	logic [31:0] t_rank [NSLOT];
	bit          t_used [NSLOT];
	bit          t_pend [NSLOT];
	bit          t_canc [NSLOT];
	logic [31:0] ver_ctr = '0;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   err_cnt = 0;
	bit   long_hold = 1'b0;

	function automatic bit is_live(int i);
		return t_used[i] && !t_pend[i];
	endfunction

	function automatic bit orders_first(int a, int b);
		if (t_due[a] != t_due[b])
			return t_due[a] < t_due[b];
		return t_rank[a] < t_rank[b];
	endfunction

	function automatic int lowest_free();
		for (int i = 0; i < NSLOT; i++)
			if (!t_used[i])
				return i;
		return -1;
	endfunction

	task automatic predict_timers(input req_t r);
		rsp_t o;
		int s;
		int n;
		int best;
		logic [31:0] arr;
		logic [31:0] nr [NSLOT];
		logic [31:0] k;
		logic [31:0] p;
		logic [31:0] c;
		o = '0;
		case (r.kind)
			KIND_SCHED: begin
				s = lowest_free();
				if (s < 0) begin
					for (int i = 0; i < NSLOT; i++)
						if (is_live(i) && t_canc[i])
							t_used[i] = 1'b0;
					s = lowest_free();
				end
				o.result_kind = RES_REPLY;
				o.last = 1'b1;
				if (s >= 0) begin
					arr = 0;
					for (int i = 0; i < NSLOT; i++)
						if (t_used[i] && t_pend[i])
							arr++;
					t_due[s] = r.now + r.delay;
					t_act[s] = r.action_tag;
					t_ver[s] = ver_ctr;
					ver_ctr = ver_ctr + 1;
					t_used[s] = 1'b1;
					t_pend[s] = 1'b1;
					t_canc[s] = 1'b0;
					t_rank[s] = arr;
					o.ok = 1'b1;
					o.out_slot = s[3:0];
					o.out_version = t_ver[s];
				end
				expected_rsps.push_back(o);
			end
			KIND_CANCEL: begin
				if (t_used[r.handle_slot] && t_ver[r.handle_slot] == r.handle_version)
					t_canc[r.handle_slot] = 1'b1;
			end
			KIND_TICK: begin
				k = 0;
				p = 0;
				for (int i = 0; i < NSLOT; i++) begin
					if (is_live(i)) begin
						c = 0;
						for (int j = 0; j < NSLOT; j++)
							if (j != i && is_live(j) && orders_first(j, i))
								c++;
						nr[i] = c;
						k++;
					end else if (t_used[i]) begin
						p++;
					end
				end
				for (int i = 0; i < NSLOT; i++) begin
					if (is_live(i)) begin
						t_rank[i] = nr[i];
					end else if (t_used[i]) begin
						// newest pending gets lowest rank
						t_rank[i] = k + (p - 1 - t_rank[i]);
						t_pend[i] = 1'b0;
					end
				end
				n = 0;
				forever begin
					best = -1;
					for (int i = 0; i < NSLOT; i++)
						if (is_live(i) && (best < 0 || orders_first(i, best)))
							best = i;
					if (best < 0 || r.now < t_due[best])
						break;
					t_used[best] = 1'b0;
					if (!t_canc[best]) begin
						o = '0;
						o.result_kind = RES_FIRED;
						o.out_slot = best[3:0];
						o.out_version = t_ver[best];
						o.fired_action = t_act[best];
						o.fire_time = r.now;
						expected_rsps.push_back(o);
						n++;
					end
				end
				if (n > 0)
					expected_rsps[$].last = 1'b1;
			end
			default: ;
		endcase
	endtask

	// Driver: bursts and gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				predict_timers(req);
				void'(pending_reqs.pop_front());
			end
			if (!(req_valid && !req_ready)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_valid <= 1'b0;
				end else if ((req_valid && req_ready ? pending_reqs.size() > 0 :
						pending_reqs.size() > 0)) begin
					req_valid <= 1'b1;
					req <= pending_reqs[0];
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						if ($urandom_range(0, 3) != 0)
							gap_left <= $urandom_range(1, 30);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern, with one long hold
	int stall_phase = 0;
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (long_hold)
			rsp_ready <= 1'b0;
		else if (stall_phase % 256 < 64)
			rsp_ready <= 1'b1;
		else
			rsp_ready <= ($urandom_range(0, 2) != 0);
	end

	// Monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected result %p", $time, rsp);
				err_cnt++;
			end else begin
				if (rsp !== expected_rsps[0]) begin
					$display("%0t: mismatch expected %p actual %p", $time,
						expected_rsps[0], rsp);
					err_cnt++;
				end
				void'(expected_rsps.pop_front());
			end
		end
	end

	function automatic req_t mk_sched(logic [31:0] t, logic [31:0] d, logic [7:0] a);
		req_t r;
		r = '0;
		r.kind = KIND_SCHED;
		r.now = t;
		r.delay = d;
		r.action_tag = a;
		return r;
	endfunction

	function automatic req_t mk_tick(logic [31:0] t);
		req_t r;
		r = '0;
		r.kind = KIND_TICK;
		r.now = t;
		return r;
	endfunction

	function automatic req_t mk_cancel(logic [3:0] s, logic [31:0] v);
		req_t r;
		r = '0;
		r.kind = KIND_CANCEL;
		r.handle_slot = s;
		r.handle_version = v;
		return r;
	endfunction

	// Versions near the live counter so cancels often hit
	function automatic logic [31:0] ver_cnt_near(int back);
		return ver_ctr - back[31:0];
	endfunction

	initial begin
		req_t r;
		int pick;
		logic [31:0] clock_now;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extremes, equal due times, wrap, full pool, cancels
		pending_reqs.push_back(mk_tick(32'd0));
		pending_reqs.push_back(mk_sched(32'd0, 32'd0, 8'h00));
		pending_reqs.push_back(mk_sched(32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF));
		pending_reqs.push_back(mk_sched(32'd5, 32'd5, 8'hA5));
		pending_reqs.push_back(mk_sched(32'd0, 32'd10, 8'h5A));
		pending_reqs.push_back(mk_cancel(4'd3, 32'd3));
		pending_reqs.push_back(mk_cancel(4'd2, 32'd7));
		pending_reqs.push_back(mk_cancel(4'd15, 32'hFFFFFFFF));
		r = mk_tick(32'd20);
		r.delay = 32'hFFFFFFFF;
		r.action_tag = 8'hFF;
		pending_reqs.push_back(r);
		r = '0;
		r.kind = KIND_RSVD;
		r.now = 32'hFFFFFFFF;
		pending_reqs.push_back(r);
		for (int i = 0; i < 17; i++)
			pending_reqs.push_back(mk_sched(32'd100, 32'd50, i[7:0]));
		pending_reqs.push_back(mk_tick(32'd100));
		pending_reqs.push_back(mk_cancel(4'd0, 32'd4));
		pending_reqs.push_back(mk_sched(32'd100, 32'd1, 8'h11));
		pending_reqs.push_back(mk_tick(32'hFFFFFFFF));
		wait (pending_reqs.size() == 0);
		// long receiver hold while the sender keeps offering
		long_hold = 1'b1;
		for (int i = 0; i < 20; i++)
			pending_reqs.push_back(mk_sched(32'd0, 32'd1, i[7:0]));
		pending_reqs.push_back(mk_tick(32'd10));
		repeat (400) @(posedge clk);
		long_hold = 1'b0;
		wait (pending_reqs.size() == 0);
		// random: mostly well-formed schedule / cancel / tick with advancing time
		clock_now = $urandom();
		for (int i = 0; i < RAND_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				r = mk_sched(clock_now, ($urandom_range(0, 3) == 0) ? $urandom() :
					$urandom_range(0, 60), 8'($urandom()));
			end else if (pick < 60) begin
				r = mk_cancel(4'($urandom()), ($urandom_range(0, 3) == 0) ? $urandom() :
					ver_cnt_near($urandom_range(0, 40)));
			end else if (pick < 95) begin
				clock_now = clock_now + $urandom_range(0, 40);
				r = mk_tick(clock_now);
				if ($urandom_range(0, 9) == 0)
					r.now = $urandom();
			end else begin
				r = '0;
				r.kind = 2'($urandom_range(0, 3));
				r.now = $urandom();
				r.delay = $urandom();
				r.action_tag = 8'($urandom());
				r.handle_slot = 4'($urandom());
				r.handle_version = $urandom();
			end
			pending_reqs.push_back(r);
		end
		pending_reqs.push_back(mk_tick(32'hFFFFFFFF));
		wait (pending_reqs.size() == 0);
		wait (expected_rsps.size() == 0);
		repeat (200) @(posedge clk);
		if (err_cnt == 0 && expected_rsps.size() == 0)
			$display("timeout_scheduler_tb: clean");
		else
			$display("timeout_scheduler_tb: errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout_scheduler_tb: errors");
		$finish;
	end
endmodule
`default_nettype wire
